[design/text_console_writer_core_macros.svh]
// Assertion macros for the console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console writer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console writer: next-cycle check failed");

`endif

[design/tcw_pkg.sv]
package tcw_pkg;

    // Field widths.
    localparam int unsigned OP_W     = 3;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned COLOUR_W = 4;
    localparam int unsigned COL_W    = 7;
    localparam int unsigned ROW_W    = 5;
    localparam int unsigned LIN_W    = COL_W + ROW_W;
    localparam int unsigned CELL_W   = CHAR_W + 2 * COLOUR_W;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    // Default geometry.
    localparam int unsigned DEF_COLUMNS   = 80;
    localparam int unsigned DEF_USER_ROWS = 23;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
    localparam logic [OP_W-1:0] OP_SET   = 3'd1;
    localparam logic [OP_W-1:0] OP_BACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    // Character codes and colour reset values.
    localparam logic [CHAR_W-1:0]   CODE_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0]   CODE_BLANK   = 8'd32;
    localparam logic [COLOUR_W-1:0] RST_FG       = 4'd15;
    localparam logic [COLOUR_W-1:0] RST_BG       = 4'd0;

    // Register index as decoded from the byte address.
    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    // One screen cell as stored.
    typedef struct packed {
        logic [COLOUR_W-1:0] bg;
        logic [COLOUR_W-1:0] fg;
        logic [CHAR_W-1:0]   ch;
    } t_cell;

endpackage

[design/text_console_writer_core.sv]
// Put without a scroll, set cursor, backspace, unknown codes and out-of-range reads: result in
// the cycle after the accepting edge, and the next command may start in the following cycle.
// An in-range read goes through the registered read of the screen memory and the read state.
// Scroll and clear sweep the screen memory one cell a cycle, over all COLUMNS*USER_ROWS cells.
// Reset is synchronous: the cursor goes to the origin and the colours to white on black;
// the screen memory is not cleared and is undefined until written. Results cannot be stalled.
`include "text_console_writer_core_macros.svh"

module text_console_writer_core #(
    parameter int unsigned COLUMNS   = tcw_pkg::DEF_COLUMNS,
    parameter int unsigned USER_ROWS = tcw_pkg::DEF_USER_ROWS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [tcw_pkg::OP_W-1:0]     i_operation,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_character,
    input  logic [tcw_pkg::COLOUR_W-1:0] i_foreground,
    input  logic [tcw_pkg::COLOUR_W-1:0] i_background,
    input  logic [tcw_pkg::COL_W-1:0]    i_column,
    input  logic [tcw_pkg::ROW_W-1:0]    i_row,
    output logic                         o_done,
    output logic [tcw_pkg::COL_W-1:0]    o_cursor_column,
    output logic [tcw_pkg::ROW_W-1:0]    o_cursor_row,
    output logic                         o_scrolled,
    output logic                         o_bad_position,
    output logic [tcw_pkg::CHAR_W-1:0]   o_cell_character,
    output logic [tcw_pkg::COLOUR_W-1:0] o_cell_foreground,
    output logic [tcw_pkg::COLOUR_W-1:0] o_cell_background,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcw_pkg::APB_AW-1:0]   paddr,
    input  logic [tcw_pkg::APB_DW-1:0]   pwdata,
    output logic [tcw_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    import tcw_pkg::*;

    localparam int unsigned CELL_COUNT = COLUMNS * USER_ROWS;
    localparam int unsigned AW         = $clog2(CELL_COUNT);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(USER_ROWS - 1);
    localparam logic [AW-1:0]    LAST_CELL = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0]    MOVE_END  = AW'(CELL_COUNT - COLUMNS);

    // Sequencer states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_SCROLL = 2'd2;
    localparam logic [1:0] S_CLEAR  = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [AW-1:0]       r_wa, n_wa;
    logic [COL_W-1:0]    r_cur_col, n_cur_col;
    logic [ROW_W-1:0]    r_cur_row, n_cur_row;
    logic [COLOUR_W-1:0] r_def_fg, r_def_bg;
    logic                r_done, n_done;
    logic                r_scrolled, n_scrolled;
    logic                r_bad, n_bad;
    t_cell               r_cell, n_cell;

    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    t_cell               mem_wd;
    logic [AW-1:0]       mem_ra;
    t_cell               mem_rd;

    logic                accept;
    logic                req_ok;
    logic [LIN_W-1:0]    req_lin;
    logic [LIN_W-1:0]    cur_lin;
    logic [LIN_W:0]      src_next;
    t_cell               blank;
    logic                cfg_write;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign blank     = '{bg: r_def_bg, fg: r_def_fg, ch: CODE_BLANK};
    assign cfg_write = psel && penable && pwrite && pready;

    // Linear cell addresses of the request and of the cursor.
    assign req_ok  = ({1'b0, i_column} < (COL_W + 1)'(COLUMNS))
                  && ({1'b0, i_row} < (ROW_W + 1)'(USER_ROWS));
    assign req_lin = LIN_W'(i_row) * LIN_W'(COLUMNS) + LIN_W'(i_column);
    assign cur_lin = LIN_W'(r_cur_row) * LIN_W'(COLUMNS) + LIN_W'(r_cur_col);

    // Source of the next scroll move, one row below the next target.
    assign src_next = (LIN_W + 1)'(r_wa) + (LIN_W + 1)'(COLUMNS + 1);

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_wa),
        .i_wdata (mem_wd),
        .i_raddr (mem_ra),
        .o_rdata (mem_rd)
    );

    // Command decode and memory sweep control.
    always_comb begin
        n_state    = r_state;
        n_wa       = r_wa;
        n_cur_col  = r_cur_col;
        n_cur_row  = r_cur_row;
        n_done     = 1'b0;
        n_scrolled = 1'b0;
        n_bad      = 1'b0;
        n_cell     = '0;
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = blank;
        mem_ra     = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_done = 1'b1;
                    case (i_operation)
                        OP_PUT: begin
                            // Prime the first scroll read in case this put scrolls.
                            mem_ra = AW'(COLUMNS);
                            if (i_character != CODE_NEWLINE) begin
                                mem_we = 1'b1;
                                mem_wa = AW'(cur_lin);
                                mem_wd = '{bg: i_background, fg: i_foreground,
                                           ch: i_character};
                            end
                            if ((i_character == CODE_NEWLINE) || (r_cur_col == LAST_COL)) begin
                                n_cur_col = '0;
                                if (r_cur_row == LAST_ROW) begin
                                    n_done  = 1'b0;
                                    n_wa    = '0;
                                    n_state = S_SCROLL;
                                end else begin
                                    n_cur_row = r_cur_row + 1'b1;
                                end
                            end else begin
                                n_cur_col = r_cur_col + 1'b1;
                            end
                        end
                        OP_SET: begin
                            if (req_ok) begin
                                n_cur_col = i_column;
                                n_cur_row = i_row;
                            end else begin
                                n_cur_col = '0;
                                n_cur_row = '0;
                                n_bad     = 1'b1;
                            end
                        end
                        OP_BACK: begin
                            // At the origin nothing changes.
                            if ((r_cur_col != '0) || (r_cur_row != '0)) begin
                                mem_we = 1'b1;
                                mem_wa = AW'(cur_lin - 1'b1);
                                if (r_cur_col != '0) begin
                                    n_cur_col = r_cur_col - 1'b1;
                                end else begin
                                    n_cur_col = LAST_COL;
                                    n_cur_row = r_cur_row - 1'b1;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            n_done  = 1'b0;
                            n_wa    = '0;
                            n_state = S_CLEAR;
                        end
                        OP_READ: begin
                            if (req_ok) begin
                                mem_ra  = AW'(req_lin);
                                n_done  = 1'b0;
                                n_state = S_READ;
                            end else begin
                                n_bad = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_done  = 1'b1;
                n_cell  = mem_rd;
                n_state = S_IDLE;
            end
            S_SCROLL: begin
                // Move each cell up a row, then blank the bottom row.
                mem_we = 1'b1;
                mem_wa = r_wa;
                mem_wd = (r_wa < MOVE_END) ? mem_rd : blank;
                if (src_next < (LIN_W + 1)'(CELL_COUNT)) begin
                    mem_ra = AW'(src_next);
                end
                if (r_wa == LAST_CELL) begin
                    n_done     = 1'b1;
                    n_scrolled = 1'b1;
                    n_cur_col  = '0;
                    n_cur_row  = LAST_ROW;
                    n_state    = S_IDLE;
                end else begin
                    n_wa = r_wa + 1'b1;
                end
            end
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_wa;
                if (r_wa == LAST_CELL) begin
                    n_done    = 1'b1;
                    n_cur_col = '0;
                    n_cur_row = '0;
                    n_state   = S_IDLE;
                end else begin
                    n_wa = r_wa + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer, cursor and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cur_col  <= '0;
            r_cur_row  <= '0;
            r_done     <= 1'b0;
            r_scrolled <= 1'b0;
            r_bad      <= 1'b0;
            r_cell     <= '0;
        end else begin
            r_state    <= n_state;
            r_cur_col  <= n_cur_col;
            r_cur_row  <= n_cur_row;
            r_done     <= n_done;
            r_scrolled <= n_scrolled;
            r_bad      <= n_bad;
            r_cell     <= n_cell;
        end
    end

    // The sweep address needs no reset: it is loaded before every sweep.
    always_ff @(posedge i_clk) begin
        r_wa <= n_wa;
    end

    // Default colour registers, written by a configuration beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_fg <= RST_FG;
            r_def_bg <= RST_BG;
        end else if (cfg_write) begin
            if (paddr[2] == REG_BG) begin
                r_def_bg <= pwdata[COLOUR_W-1:0];
            end else begin
                r_def_fg <= pwdata[COLOUR_W-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BG) ? APB_DW'(r_def_bg) : APB_DW'(r_def_fg);

    assign o_done            = r_done;
    assign o_cursor_column   = r_cur_col;
    assign o_cursor_row      = r_cur_row;
    assign o_scrolled        = r_scrolled;
    assign o_bad_position    = r_bad;
    assign o_cell_character  = r_cell.ch;
    assign o_cell_foreground = r_cell.fg;
    assign o_cell_background = r_cell.bg;

    // A reported cursor always lies on the screen.
    `TCW_ASSERT_IMP(a_cursor_range, i_clk, i_rst_n, o_done,
        ({1'b0, r_cur_col} < (COL_W + 1)'(COLUMNS)) && ({1'b0, r_cur_row} < (ROW_W + 1)'(USER_ROWS)))
    // A scroll leaves the cursor at the start of the bottom row.
    `TCW_ASSERT_IMP(a_scroll_cursor, i_clk, i_rst_n, o_scrolled,
        o_done && (r_cur_col == '0) && (r_cur_row == LAST_ROW))
    // A bad position is only flagged on a result carrying no cell contents.
    `TCW_ASSERT_IMP(a_bad_no_cell, i_clk, i_rst_n, o_bad_position,
        o_done && (r_cell == '0) && !o_scrolled)
    // Setting the cursor reports its result in the next cycle and leaves the block free.
    `TCW_ASSERT_NXT(a_set_single, i_clk, i_rst_n, accept && (i_operation == OP_SET),
        o_done && !busy)

endmodule

[design/tcw_ram.sv]
module tcw_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1840,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
